[hw/rtl/olfp_pkg.sv]
// Shared constants and types for the opcode/length frame parser.
`timescale 1ns / 1ps

package olfp_pkg;

    localparam int unsigned PAYLOAD_LEN_W = 24;
    localparam int unsigned SIZE_W        = 16;
    localparam int unsigned CFG_DATA_W    = 24;
    localparam int unsigned CFG_INDEX_W   = 3;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    // Configuration register indexes
    localparam t_cfg_index REG_MAX_PAYLOAD = 3'd0;
    localparam t_cfg_index REG_MIN_COLUMNS = 3'd1;
    localparam t_cfg_index REG_MAX_COLUMNS = 3'd2;
    localparam t_cfg_index REG_MIN_ROWS    = 3'd3;
    localparam t_cfg_index REG_MAX_ROWS    = 3'd4;

    localparam logic [PAYLOAD_LEN_W-1:0] RST_MAX_PAYLOAD = 24'd131072;
    localparam logic [SIZE_W-1:0]        RST_MIN_COLUMNS = 16'd2;
    localparam logic [SIZE_W-1:0]        RST_MAX_COLUMNS = 16'd1000;
    localparam logic [SIZE_W-1:0]        RST_MIN_ROWS    = 16'd1;
    localparam logic [SIZE_W-1:0]        RST_MAX_ROWS    = 16'd500;

    // Result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_RESIZE   = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [1:0] KIND_BAD      = 2'd3;

    // Limits the parser needs from the register file
    typedef struct packed {
        logic [PAYLOAD_LEN_W-1:0] max_payload;
        logic                     size_ok;
    } t_cfg_view;

endpackage

[hw/rtl/opcode_length_frame_parser.sv]
// Top level: byte-serial opcode/length/payload frame parser.
//
// Input channel: i_valid/o_stall carry one stream byte per transfer.
// Output channel: o_valid/i_stall carry at most one result per input byte:
// a payload byte (with last-of-frame mark), a resize, or a stop code.
// Frames are an opcode byte, a 32-bit little-endian length, then payload.
// Each byte is decoded in the cycle it is taken; its result sits in the
// output register from the next cycle, and the sustained rate is 1 byte
// per clock. The single output register sets that rate:
// o_stall rises only while a result is held and the receiver stalls.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data)
// and should be written only while the parser is idle.
// Reset (synchronous, active low) restores the register defaults, returns
// the parser to waiting for an opcode and clears the halted flag.
// After an oversize length or a bad frame the parser gives one stop result
// and then swallows every byte until reset.
`timescale 1ns / 1ps

module opcode_length_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_stream_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_result_kind,
    output logic [7:0]                        o_data_byte,
    output logic                              o_last_of_frame,
    output logic [olfp_pkg::SIZE_W-1:0]       o_new_columns,
    output logic [olfp_pkg::SIZE_W-1:0]       o_new_rows,
    input  logic                              i_cfg_we,
    input  olfp_pkg::t_cfg_index              i_cfg_index,
    input  logic [olfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import olfp_pkg::*;

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_RESIZE  = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_RESIZE = 2'd1;
    localparam logic [1:0] OP_OTHER  = 2'd2;

    logic [2:0]               r_phase,  n_phase;
    logic [1:0]               r_opcls,  n_opcls;
    logic [1:0]               r_hidx,   n_hidx;
    logic [PAYLOAD_LEN_W-1:0] r_remain, n_remain;
    logic [23:0]              r_rsz,    n_rsz;
    logic                     r_halted, n_halted;

    logic                     r_out_valid;
    logic [1:0]               r_kind;
    logic [7:0]               r_data;
    logic                     r_last;
    logic [SIZE_W-1:0]        r_cols;
    logic [SIZE_W-1:0]        r_rows;

    logic                     in_xfer;
    logic                     emit;
    logic [1:0]               emit_kind;
    logic                     emit_last;
    logic                     emit_size;
    logic [PAYLOAD_LEN_W-1:0] remain_dec;
    logic [1:0]               rsz_pos;
    logic [SIZE_W-1:0]        cand_cols;
    logic [SIZE_W-1:0]        cand_rows;
    t_cfg_view                cfg;

    assign o_stall = r_out_valid & i_stall;
    assign in_xfer = i_valid & ~o_stall;

    assign remain_dec = r_remain - PAYLOAD_LEN_W'(1);
    // remaining 4,3,2 maps to resize byte 0,1,2
    assign rsz_pos    = 2'(2'd0 - r_remain[1:0]);
    assign cand_cols  = r_rsz[15:0];
    assign cand_rows  = {i_stream_byte, r_rsz[23:16]};

    olfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_columns   (cand_cols),
        .i_rows      (cand_rows),
        .o_view      (cfg)
    );

    always_comb begin
        n_phase   = r_phase;
        n_opcls   = r_opcls;
        n_hidx    = r_hidx;
        n_remain  = r_remain;
        n_rsz     = r_rsz;
        n_halted  = r_halted;
        emit      = 1'b0;
        emit_kind = KIND_DATA;
        emit_last = 1'b0;
        emit_size = 1'b0;
        if (in_xfer && !r_halted) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (r_hidx != 2'd3) begin
                        unique case (r_hidx)
                            2'd0:    n_remain[7:0]   = i_stream_byte;
                            2'd1:    n_remain[15:8]  = i_stream_byte;
                            default: n_remain[23:16] = i_stream_byte;
                        endcase
                        n_hidx = r_hidx + 2'd1;
                    end else begin
                        n_hidx = 2'd0;
                        n_rsz  = '0;
                        // top length byte set means above any 24-bit limit
                        priority if (i_stream_byte != 8'd0 ||
                                     r_remain > cfg.max_payload) begin
                            n_halted  = 1'b1;
                            n_phase   = PH_OPCODE;
                            emit      = 1'b1;
                            emit_kind = KIND_OVERSIZE;
                        end else if (r_opcls == OP_DATA) begin
                            n_phase = (r_remain == '0) ? PH_OPCODE : PH_DATA;
                        end else if (r_opcls == OP_RESIZE &&
                                     r_remain == PAYLOAD_LEN_W'(4)) begin
                            n_phase = PH_RESIZE;
                        end else if (r_remain == '0) begin
                            n_halted  = 1'b1;
                            n_phase   = PH_OPCODE;
                            emit      = 1'b1;
                            emit_kind = KIND_BAD;
                        end else begin
                            n_phase = PH_DISCARD;
                        end
                    end
                end
                PH_DATA: begin
                    n_remain  = remain_dec;
                    emit      = 1'b1;
                    emit_kind = KIND_DATA;
                    if (remain_dec == '0) begin
                        n_phase   = PH_OPCODE;
                        emit_last = 1'b1;
                    end
                end
                PH_RESIZE: begin
                    n_remain = remain_dec;
                    if (remain_dec != '0) begin
                        unique case (rsz_pos)
                            2'd0:    n_rsz[7:0]   = i_stream_byte;
                            2'd1:    n_rsz[15:8]  = i_stream_byte;
                            default: n_rsz[23:16] = i_stream_byte;
                        endcase
                    end else begin
                        n_phase = PH_OPCODE;
                        if (cfg.size_ok) begin
                            emit      = 1'b1;
                            emit_kind = KIND_RESIZE;
                            emit_size = 1'b1;
                        end
                    end
                end
                PH_DISCARD: begin
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        n_halted  = 1'b1;
                        n_phase   = PH_OPCODE;
                        emit      = 1'b1;
                        emit_kind = KIND_BAD;
                    end
                end
                default: begin
                    priority if (i_stream_byte == 8'd0) n_opcls = OP_DATA;
                    else if (i_stream_byte == 8'd1)     n_opcls = OP_RESIZE;
                    else                                n_opcls = OP_OTHER;
                    n_hidx   = 2'd0;
                    n_remain = '0;
                    n_phase  = PH_LENGTH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_opcls     <= OP_DATA;
            r_hidx      <= 2'd0;
            r_remain    <= '0;
            r_rsz       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcls  <= n_opcls;
            r_hidx   <= n_hidx;
            r_remain <= n_remain;
            r_rsz    <= n_rsz;
            r_halted <= n_halted;
            if (in_xfer) begin
                r_out_valid <= emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_kind <= emit_kind;
            r_data <= (emit_kind == KIND_DATA) ? i_stream_byte : 8'd0;
            r_last <= emit_last;
            r_cols <= emit_size ? cand_cols : '0;
            r_rows <= emit_size ? cand_rows : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_data_byte     = r_data;
    assign o_last_of_frame = r_last;
    assign o_new_columns   = r_cols;
    assign o_new_rows      = r_rows;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_halt_gives_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> r_out_valid &&
            (r_kind == KIND_OVERSIZE || r_kind == KIND_BAD))
        else $error("stop entered without a stop result");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && in_xfer |=> !r_out_valid)
        else $error("result produced while halted");

    a_resize_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RESIZE |-> r_remain != '0 && r_remain <= PAYLOAD_LEN_W'(4))
        else $error("resize byte count out of range");

    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA || r_phase == PH_DISCARD |-> r_remain != '0)
        else $error("payload phase with nothing left");

endmodule

[hw/rtl/olfp_cfg.sv]
// Configuration registers and resize bounds check.
`timescale 1ns / 1ps

module olfp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  olfp_pkg::t_cfg_index              i_cfg_index,
    input  logic [olfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [olfp_pkg::SIZE_W-1:0]       i_columns,
    input  logic [olfp_pkg::SIZE_W-1:0]       i_rows,
    output olfp_pkg::t_cfg_view               o_view
);
    import olfp_pkg::*;

    logic [PAYLOAD_LEN_W-1:0] r_max_payload;
    logic [SIZE_W-1:0]        r_min_columns;
    logic [SIZE_W-1:0]        r_max_columns;
    logic [SIZE_W-1:0]        r_min_rows;
    logic [SIZE_W-1:0]        r_max_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= RST_MAX_PAYLOAD;
            r_min_columns <= RST_MIN_COLUMNS;
            r_max_columns <= RST_MAX_COLUMNS;
            r_min_rows    <= RST_MIN_ROWS;
            r_max_rows    <= RST_MAX_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[PAYLOAD_LEN_W-1:0];
                REG_MIN_COLUMNS: r_min_columns <= i_cfg_data[SIZE_W-1:0];
                REG_MAX_COLUMNS: r_max_columns <= i_cfg_data[SIZE_W-1:0];
                REG_MIN_ROWS:    r_min_rows    <= i_cfg_data[SIZE_W-1:0];
                REG_MAX_ROWS:    r_max_rows    <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // min above max gives an empty range, so nothing passes
    assign o_view.max_payload = r_max_payload;
    assign o_view.size_ok     = (i_columns >= r_min_columns) && (i_columns <= r_max_columns) &&
                                (i_rows >= r_min_rows) && (i_rows <= r_max_rows);

endmodule
